### rtl/core/u2h_pkg.sv
// ----------------------------------------------------------------------------
// u2h_pkg
// Shared types, constants and the hex digit function for the UTF-8 to UCS-2
// hex encoder.
// ----------------------------------------------------------------------------
package u2h_pkg;

	localparam int CODE_W      = 16;
	localparam int BYTE_W      = 8;
	localparam int CHAR_W      = 7;
	localparam int REM_W       = 3;
	localparam int DIGITS      = 4;
	localparam int DIGIT_W     = 2;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] CONT_PREFIX = 2'b10;

	// code handed from the decoder to the queue, and from the queue to the serializer
	typedef struct packed {
		logic              valid;
		logic [CODE_W-1:0] code;
	} code_xfer_t;

	// ascii lowercase hex digit of one nibble
	function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] v);
		logic [CHAR_W-1:0] r;
		if (v < 4'd10) begin
			r = 7'h30 + {3'b000, v};
		end else begin
			r = 7'h57 + {3'b000, v};
		end
		return r;
	endfunction

endpackage

### rtl/core/u2h_front.sv
// ----------------------------------------------------------------------------
// u2h_front
// Accepts UTF-8 bytes, tracks the open sequence and pushes each finished
// nonzero 16-bit code into the queue.
// ----------------------------------------------------------------------------
module u2h_front
	import u2h_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              end_of_message,
	output code_xfer_t        push
);

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [BYTE_W-1:0] mask;
	} lead_t;

	// continuation bytes still expected and payload mask of a lead byte
	function automatic lead_t lead_decode(input logic [BYTE_W-1:0] b);
		lead_t r;
		unique casez (b)
			8'b0???????: r = '{rem: 3'd0, mask: 8'hFF};
			8'b10??????: r = '{rem: 3'd0, mask: 8'hFF};
			8'b110?????: r = '{rem: 3'd1, mask: 8'h1F};
			8'b1110????: r = '{rem: 3'd2, mask: 8'h0F};
			8'b11110???: r = '{rem: 3'd3, mask: 8'h07};
			8'b111110??: r = '{rem: 3'd4, mask: 8'h03};
			8'b1111110?: r = '{rem: 3'd5, mask: 8'h01};
			8'b11111110: r = '{rem: 3'd6, mask: 8'h00};
			default:     r = '{rem: 3'd0, mask: 8'hFF};
		endcase
		return r;
	endfunction

	logic [REM_W-1:0]  rem_q, rem_n;
	logic [CODE_W-1:0] acc_q, acc_n;
	logic              bad_q, bad_n;
	logic              emit;
	logic [CODE_W-1:0] emit_code;
	lead_t             lead;

	// next sequence state and finished code
	always_comb begin
		lead      = lead_decode(data_byte);
		rem_n     = rem_q;
		acc_n     = acc_q;
		bad_n     = bad_q;
		emit      = 1'b0;
		emit_code = {{(CODE_W-BYTE_W){1'b0}}, data_byte};
		if (rem_q == '0) begin
			if (lead.rem == '0) begin
				emit = (data_byte != '0);
			end else begin
				acc_n = {{(CODE_W-BYTE_W){1'b0}}, data_byte & lead.mask};
				rem_n = lead.rem;
				bad_n = 1'b0;
			end
		end else begin
			bad_n     = bad_q | (data_byte[7:6] != CONT_PREFIX);
			acc_n     = {acc_q[CODE_W-7:0], data_byte[5:0]};
			rem_n     = rem_q - 3'd1;
			emit_code = acc_n;
			if (rem_n == '0) begin
				emit  = !bad_n && (acc_n != '0);
				acc_n = '0;
				bad_n = 1'b0;
			end
		end
		// end of message drops any open sequence
		if (end_of_message) begin
			rem_n = '0;
			acc_n = '0;
			bad_n = 1'b0;
		end
	end

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			acc_q <= '0;
			bad_q <= 1'b0;
		end else if (accept) begin
			rem_q <= rem_n;
			acc_q <= acc_n;
			bad_q <= bad_n;
		end
	end

	assign push.valid = accept && emit;
	assign push.code  = emit_code;

endmodule

### rtl/core/u2h_queue.sv
// ----------------------------------------------------------------------------
// u2h_queue
// Short code queue between the decoder and the hex serializer.
// ----------------------------------------------------------------------------
module u2h_queue
	import u2h_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  code_xfer_t push,
	output logic       full,
	input  logic       pop_req,
	output code_xfer_t head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CODE_W-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.code  = entry_q[rd_ptr_q];
	assign do_pop     = pop_req && head.valid;

	// storage
	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_ptr_q] <= push.code;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push.valid && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push.valid && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/u2h_back.sv
// ----------------------------------------------------------------------------
// u2h_back
// Takes codes from the queue and sends four hex characters per code,
// most significant digit first, through an output register.
// ----------------------------------------------------------------------------
module u2h_back
	import u2h_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  code_xfer_t        head,
	output logic              pop_req,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAR_W-1:0] hex_char,
	output logic              last_of_code
);

	logic [CODE_W-1:0]  code_q;
	logic [DIGIT_W-1:0] digit_q;
	logic               active_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;
	logic               out_free;
	logic               last_digit;
	logic               take;
	logic [3:0]         nibble;

	assign out_free   = !out_valid_q || out_ready;
	assign last_digit = (digit_q == DIGIT_W'(DIGITS - 1));
	assign pop_req    = !active_q || (out_free && last_digit);
	assign take       = pop_req && head.valid;

	// nibble for the current digit
	always_comb begin
		case (digit_q)
			2'd0:    nibble = code_q[15:12];
			2'd1:    nibble = code_q[11:8];
			2'd2:    nibble = code_q[7:4];
			default: nibble = code_q[3:0];
		endcase
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_free && active_q) begin
			char_q <= hex_digit(nibble);
			last_q <= last_digit;
		end
		if (take) begin
			code_q <= head.code;
		end
	end

	// digit sequencing and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			active_q    <= 1'b0;
			digit_q     <= '0;
		end else begin
			if (out_free) begin
				out_valid_q <= active_q;
			end
			if (take) begin
				active_q <= 1'b1;
				digit_q  <= '0;
			end else if (active_q && out_free) begin
				digit_q <= digit_q + 1'b1;
				if (last_digit) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign hex_char     = char_q;
	assign last_of_code = last_q;

endmodule

### rtl/core/utf8_to_ucs2_hex_encoder_core.sv
// Path: a byte that completes a code writes it into the code queue; the serializer loads it
// into its code register and sends the four hex characters through the output register.
// Throughput: one character per cycle out while m_tready is high, four characters per code;
// bytes that yield nothing are taken one per cycle while the code queue has room.
// Reset: arst_n clears the open sequence, the code queue and the output valid flag.
// ----------------------------------------------------------------------------
// utf8_to_ucs2_hex_encoder_core
// UTF-8 byte stream in, four lowercase hex characters per nonzero 16-bit code out.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_hex_encoder_core
	import u2h_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] data_byte
	input  logic       s_tlast,  // end_of_message
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [6:0] hex_char, [7] zero
	output logic       m_tlast   // last_of_code
);

	code_xfer_t        push;
	code_xfer_t        head;
	logic              full;
	logic              pop_req;
	logic              accept;
	logic [CHAR_W-1:0] hex_char;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	// decoder front
	u2h_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.data_byte      (s_tdata),
		.end_of_message (s_tlast),
		.push           (push)
	);

	// code queue
	u2h_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.pop_req (pop_req),
		.head    (head)
	);

	// hex serializer
	u2h_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop_req      (pop_req),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.hex_char     (hex_char),
		.last_of_code (m_tlast)
	);

	assign m_tdata = {1'b0, hex_char};

endmodule
